>>> design/mbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helper functions for the masked bit-field codec.
// No dependencies; used by masked_bitfield_codec.

package mbc_pkg;

    localparam int MAX_FIELD_BYTES = 4;
    localparam int WIN_W           = 32;
    localparam int RANK_W          = $clog2(WIN_W);
    localparam int CNT_W           = RANK_W + 1;
    localparam int OFF_W           = 16;
    localparam int LEN_W           = 16;
    localparam int SIZE_W          = 3;
    localparam int NEED_W          = OFF_W + 1;
    localparam int CFG_IDX_W       = 2;

    // Mask bits beyond the largest field size are ignored
    localparam logic [WIN_W-1:0] LIMIT_MASK = (MAX_FIELD_BYTES >= 4) ? {WIN_W{1'b1}} :
        WIN_W'((64'd1 << (8 * MAX_FIELD_BYTES)) - 64'd1);

    localparam logic [WIN_W-1:0] RST_FIELD_MASK   = 32'h0000_00FF;
    localparam logic [OFF_W-1:0] RST_FIELD_OFFSET = '0;
    localparam logic             RST_SIGN_EXTEND  = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_MASK   = 2'd0,
        CFG_FIELD_OFFSET = 2'd1,
        CFG_SIGN_EXTEND  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_opcode;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef t_cnt [WIN_W-1:0]  t_cnt_vec;
    typedef logic [RANK_W-1:0] t_rank;
    typedef t_rank [WIN_W-1:0] t_rank_vec;

    // Inclusive running popcount, log-depth prefix network
    function automatic t_cnt_vec prefix_count(logic [WIN_W-1:0] m);
        t_cnt_vec c;
        t_cnt_vec nxt;
        for (int i = 0; i < WIN_W; i++) begin
            c[i] = t_cnt'(m[i]);
        end
        for (int lv = 0; lv < RANK_W; lv++) begin
            nxt = c;
            for (int i = 0; i < WIN_W; i++) begin
                if (i >= (1 << lv)) begin
                    nxt[i] = c[i] + c[i - (1 << lv)];
                end
            end
            c = nxt;
        end
        return c;
    endfunction

    // Position of each mask bit among the set bits below it
    function automatic t_rank_vec mask_rank(logic [WIN_W-1:0] m, t_cnt_vec c);
        t_rank_vec r;
        for (int i = 0; i < WIN_W; i++) begin
            r[i] = t_rank'(c[i] - t_cnt'(m[i]));
        end
        return r;
    endfunction

    // Bytes up to and including the highest nonzero mask byte
    function automatic logic [SIZE_W-1:0] field_bytes(logic [WIN_W-1:0] m);
        logic [SIZE_W-1:0] n;
        n = '0;
        for (int b = 0; b < WIN_W / 8; b++) begin
            if (m[8*b +: 8] != 8'h00) begin
                n = SIZE_W'(b + 1);
            end
        end
        return n;
    endfunction

    // Bits at or above the field width, for sign extension
    function automatic logic [WIN_W-1:0] high_mask(t_cnt cnt);
        logic [WIN_W-1:0] h;
        for (int i = 0; i < WIN_W; i++) begin
            h[i] = (t_cnt'(i) >= cnt);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

>>> design/masked_bitfield_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// Masked bit-field codec: deposit a value into, or gather it from, a masked
// window of up to four bytes. Top level; depends on mbc_pkg.
//
// Usage:
//   Input words arrive on s_axis (tuser = opcode, tdata = value, window, length).
//   Results leave on m_axis (tuser = ok, tdata = new window, decoded value).
//   Configuration is written through the cfg channel (index 0 mask, 1 offset,
//   2 sign extend), which is always ready. The user must write it only while no
//   word is in flight; the block itself does not enforce this.
//   An accepted word passes through the input register, a single pass of
//   scatter/gather logic and the result register, which offers it on m_axis.
//   Throughput is one word per cycle while the receiver does not stall.
//   Per-mask bit ranks, field size and extension mask are registered beside
//   the configuration, so the data path is a rank-indexed select per bit.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_axis_tready drops only once both are occupied.
//   Reset (synchronous, active low) empties both stages and restores the
//   mask to 0xFF, offset 0 and sign extension off.

module masked_bitfield_codec (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data,
    // input words
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [79:0]                    s_axis_tdata,  // value, window, msg_length
    input  wire logic [0:0]                     s_axis_tuser,  // opcode[0]
    // result words
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [63:0]                         m_axis_tdata,  // new_window, decoded_value
    output logic [0:0]                          m_axis_tuser   // ok[0]
);

    localparam int WIN_W = mbc_pkg::WIN_W;

    // configuration and derived mask information
    logic [WIN_W-1:0]               r_field_mask, n_field_mask;
    logic [mbc_pkg::OFF_W-1:0]      r_field_offset, n_field_offset;
    logic                           r_sign_extend, n_sign_extend;

    mbc_pkg::t_cnt_vec              w_prefix;
    logic [WIN_W-1:0]               w_mask_lim;
    mbc_pkg::t_rank_vec             r_rank;
    logic [mbc_pkg::NEED_W-1:0]     r_need;
    logic                           r_sext_on;
    mbc_pkg::t_rank                 r_top;
    logic [WIN_W-1:0]               r_hi_mask;

    // input stage
    logic                           r_s1_valid;
    logic                           r_s1_op;
    logic [WIN_W-1:0]               r_s1_value;
    logic [WIN_W-1:0]               r_s1_window;
    logic [mbc_pkg::LEN_W-1:0]      r_s1_len;

    // result stage
    logic                           r_out_valid;
    logic                           r_out_ok;
    logic [WIN_W-1:0]               r_out_window;
    logic [WIN_W-1:0]               r_out_dv;

    logic                           w_s1_adv;
    logic                           w_in_acc;
    logic                           w_ok;
    logic [WIN_W-1:0]               w_dep;
    logic [WIN_W-1:0]               w_gather;
    logic                           w_sign;
    logic [WIN_W-1:0]               w_new_window;
    logic [WIN_W-1:0]               w_dv;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_field_mask   = r_field_mask;
        n_field_offset = r_field_offset;
        n_sign_extend  = r_sign_extend;
        if (!i_rst_n) begin
            n_field_mask   = mbc_pkg::RST_FIELD_MASK;
            n_field_offset = mbc_pkg::RST_FIELD_OFFSET;
            n_sign_extend  = mbc_pkg::RST_SIGN_EXTEND;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbc_pkg::CFG_FIELD_MASK:   n_field_mask   = i_cfg_data;
                mbc_pkg::CFG_FIELD_OFFSET: n_field_offset = i_cfg_data[mbc_pkg::OFF_W-1:0];
                mbc_pkg::CFG_SIGN_EXTEND:  n_sign_extend  = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_mask_lim = n_field_mask & mbc_pkg::LIMIT_MASK;
    assign w_prefix   = mbc_pkg::prefix_count(w_mask_lim);

    always_ff @(posedge i_clk) begin
        r_field_mask   <= w_mask_lim;
        r_field_offset <= n_field_offset;
        r_sign_extend  <= n_sign_extend;
        // derived values follow the next-state config so they stay in step
        r_rank    <= mbc_pkg::mask_rank(w_mask_lim, w_prefix);
        r_need    <= mbc_pkg::NEED_W'(n_field_offset)
                   + mbc_pkg::NEED_W'(mbc_pkg::field_bytes(w_mask_lim));
        r_sext_on <= n_sign_extend && (w_prefix[WIN_W-1] != '0);
        r_top     <= mbc_pkg::t_rank'(w_prefix[WIN_W-1] - mbc_pkg::t_cnt'(1));
        r_hi_mask <= mbc_pkg::high_mask(w_prefix[WIN_W-1]);
    end

    // handshake
    assign w_s1_adv      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_op     <= s_axis_tuser[0];
            r_s1_value  <= s_axis_tdata[31:0];
            r_s1_window <= s_axis_tdata[63:32];
            r_s1_len    <= s_axis_tdata[79:64];
        end
    end

    // scatter / gather
    always_comb begin
        w_dep    = '0;
        w_gather = '0;
        for (int p = 0; p < WIN_W; p++) begin
            w_dep[p] = r_field_mask[p] & r_s1_value[r_rank[p]];
        end
        for (int n = 0; n < WIN_W; n++) begin
            for (int p = 0; p < WIN_W; p++) begin
                if (r_field_mask[p] && (r_rank[p] == mbc_pkg::t_rank'(n))) begin
                    w_gather[n] = w_gather[n] | r_s1_window[p];
                end
            end
        end
    end

    assign w_ok   = (r_need <= mbc_pkg::NEED_W'(r_s1_len));
    assign w_sign = r_sext_on & w_gather[r_top];

    always_comb begin
        w_new_window = r_s1_window;
        w_dv         = '0;
        if (w_ok) begin
            unique case (mbc_pkg::t_opcode'(r_s1_op))
                mbc_pkg::OP_ENCODE: begin
                    w_new_window = (r_s1_window & ~r_field_mask) | w_dep;
                end
                mbc_pkg::OP_DECODE: begin
                    w_dv = w_gather | ({WIN_W{w_sign}} & r_hi_mask);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_ok     <= w_ok;
            r_out_window <= w_new_window;
            r_out_dv     <= w_dv;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_dv, r_out_window};
    assign m_axis_tuser[0] = r_out_ok;

    // checks
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_dv == '0)
        else $error("failed operation returned a nonzero decoded value");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted word did not reach the input stage");

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("advanced word did not reach the result stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !w_s1_adv)
        else $error("input stage overwrote a stalled result");

endmodule

`default_nettype wire

>>> test/masked_bitfield_codec_test.sv
`timescale 1ns / 1ps
// Self-checking bench for masked_bitfield_codec: directed table, then phases under fixed
// or random mask, offset and sign setting. Depends on mbc_pkg and the codec RTL.

module masked_bitfield_codec_test;
    import mbc_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int N_PHASES      = 10;
    localparam int PHASE_WORDS   = 125;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic               ok;
        logic [31:0]        new_window;
        logic signed [31:0] decoded_value;
    } t_field_result;

    typedef struct packed {
        t_opcode       op;
        logic [31:0]   value;
        logic [31:0]   window;
        logic [15:0]   len;
        logic          typed;
        t_field_result want;
    } t_word;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [31:0] data;
        t_word       w;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    masked_bitfield_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the codec registers, updated when a write is accepted
    logic [31:0] mask_shadow   = RST_FIELD_MASK;
    logic [15:0] offset_shadow = RST_FIELD_OFFSET;
    logic        sext_shadow   = RST_SIGN_EXTEND;

    t_word         offered_words[$];
    t_field_result pending_results[$];
    int            n_mismatch = 0;
    int            cycles     = 0;
    bit            rx_stalls  = 1'b0;
    bit            tx_gaps    = 1'b1;
    int            rx_count   = 0;
    int            burst_left = 0;

    function automatic int field_size(logic [31:0] m);
        int n;
        n = 0;
        for (int b = 0; b < 4; b++) begin
            if (m[8*b +: 8] != 8'h00) begin
                n = b + 1;
            end
        end
        return n;
    endfunction

    function automatic t_field_result compute_field(t_opcode op, logic [31:0] value,
                                                    logic [31:0] window, logic [15:0] len);
        t_field_result r;
        logic [31:0]   m;
        logic [31:0]   packed_bits;
        logic [31:0]   ext;
        int            k;
        m = mask_shadow & LIMIT_MASK;
        r.ok = 1'b0;
        r.new_window = window;
        r.decoded_value = '0;
        packed_bits = '0;
        k = 0;
        if (({1'b0, offset_shadow} + 17'(field_size(m))) <= {1'b0, len}) begin
            r.ok = 1'b1;
            if (op == OP_ENCODE) begin
                for (int pos = 0; pos < 32; pos++) begin
                    if (m[pos]) begin
                        packed_bits[pos] = value[k];
                        k++;
                    end
                end
                r.new_window = (window & ~m) | packed_bits;
            end else begin
                for (int pos = 0; pos < 32; pos++) begin
                    if (m[pos]) begin
                        packed_bits[k] = window[pos];
                        k++;
                    end
                end
                // sign taken from the top gathered bit
                if (sext_shadow && k > 0) begin
                    ext = 32'd1 << (k - 1);
                    packed_bits = (packed_bits ^ ext) - ext;
                end
                r.decoded_value = packed_bits;
            end
        end
        return r;
    endfunction

    function automatic t_stim_row cfg_row(t_cfg_idx idx, logic [31:0] data);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_stim_row word_row(t_opcode op, logic [31:0] value,
                                           logic [31:0] window, logic [15:0] len);
        t_stim_row r;
        r = '0;
        r.w.op = op;
        r.w.value = value;
        r.w.window = window;
        r.w.len = len;
        return r;
    endfunction

    function automatic t_stim_row typed_row(t_opcode op, logic [31:0] value,
                                            logic [31:0] window, logic [15:0] len,
                                            logic ok, logic [31:0] nw, logic [31:0] dv);
        t_stim_row r;
        r = word_row(op, value, window, len);
        r.w.typed = 1'b1;
        r.w.want.ok = ok;
        r.w.want.new_window = nw;
        r.w.want.decoded_value = dv;
        return r;
    endfunction

    function automatic logic [31:0] pick_mask();
        logic [31:0] m;
        int          nb;
        case ($urandom_range(0, 9))
            0: m = 32'h0;
            1: m = 32'hFFFF_FFFF;
            2: m = 32'd1 << $urandom_range(0, 31);
            3, 4, 5: begin
                nb = $urandom_range(1, 4);
                m = $urandom;
                if (nb < 4) begin
                    m = m & ((32'd1 << (8 * nb)) - 32'd1);
                end
                m[8*(nb-1) +: 8] = m[8*(nb-1) +: 8] | (8'd1 << $urandom_range(0, 7));
            end
            6: m = 32'hFF << (8 * $urandom_range(0, 3));
            default: m = $urandom;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] pick_offset();
        logic [15:0] o;
        case ($urandom_range(0, 7))
            0: o = 16'h0000;
            1: o = 16'hFFFF;
            2: o = 16'($urandom_range(65530, 65535));
            3: o = 16'($urandom);
            default: o = 16'($urandom_range(0, 16));
        endcase
        return o;
    endfunction

    // receiver: alternating runs and stalls of random length, or always ready when stalls are off
    always @(posedge i_clk) begin
        if (!rx_stalls) begin
            m_axis_tready <= 1'b1;
            rx_count <= 0;
        end else if (rx_count == 0) begin
            m_axis_tready <= !m_axis_tready;
            rx_count <= m_axis_tready ? $urandom_range(1, 12) : $urandom_range(0, 8);
        end else begin
            rx_count <= rx_count - 1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_field_result got;
        t_field_result due;
        t_word         w;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FIELD_MASK:   mask_shadow = i_cfg_data;
                    CFG_FIELD_OFFSET: offset_shadow = i_cfg_data[15:0];
                    CFG_SIGN_EXTEND:  sext_shadow = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.ok = m_axis_tuser[0];
                got.new_window = m_axis_tdata[31:0];
                got.decoded_value = m_axis_tdata[63:32];
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= REPORT_LIMIT) begin
                        $display("unexpected result word: ok=%0b new_window=%h decoded=%h",
                                 got.ok, got.new_window, got.decoded_value);
                    end
                end else begin
                    due = pending_results.pop_front();
                    if (got.ok !== due.ok || got.new_window !== due.new_window ||
                        got.decoded_value !== due.decoded_value) begin
                        n_mismatch++;
                        if (n_mismatch <= REPORT_LIMIT) begin
                            $display("mismatch: ok %0b/%0b new_window %h/%h decoded %h/%h",
                                     due.ok, got.ok, due.new_window, got.new_window,
                                     due.decoded_value, got.decoded_value);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready && offered_words.size() != 0) begin
                w = offered_words.pop_front();
                due = w.typed ? w.want : compute_field(w.op, w.value, w.window, w.len);
                pending_results.push_back(due);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (offered_words.size() != 0 || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(t_word w);
        int gap;
        if (burst_left == 0) begin
            gap = tx_gaps ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.len, w.window, w.value};
        s_axis_tuser  <= w.op;
        offered_words.push_back(w);
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    initial begin
        t_stim_row   rows[$];
        t_stim_row   r;
        logic [31:0] pm;
        logic [15:0] po;
        int          need;
        int          len;

        // reset settings first: mask 0xFF, offset 0, no sign extension
        rows.push_back(typed_row(OP_ENCODE, 32'h0000_00A5, 32'h0, 16'd1, 1, 32'hA5, 0));
        rows.push_back(typed_row(OP_ENCODE, 32'hFFFF_FFFF, 32'hFFFF_FF00, 16'd1,
                                 1, 32'hFFFF_FFFF, 0));
        rows.push_back(typed_row(OP_ENCODE, 32'h8000_0000, 32'h1234_5678, 16'hFFFF,
                                 1, 32'h1234_5600, 0));
        rows.push_back(typed_row(OP_ENCODE, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 1, 32'hFF, 0));
        rows.push_back(typed_row(OP_ENCODE, 32'h5A, 32'hCAFE_F00D, 16'd0,
                                 0, 32'hCAFE_F00D, 0));
        rows.push_back(typed_row(OP_DECODE, 32'h0, 32'h1234_56C3, 16'd1,
                                 1, 32'h1234_56C3, 32'hC3));
        rows.push_back(typed_row(OP_DECODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                 1, 32'hFFFF_FFFF, 32'hFF));
        rows.push_back(typed_row(OP_DECODE, 32'h0, 32'hFF, 16'd0, 0, 32'hFF, 0));
        rows.push_back(cfg_row(CFG_SIGN_EXTEND, 32'd1));
        rows.push_back(typed_row(OP_DECODE, 32'h0, 32'h80, 16'd1, 1, 32'h80, 32'hFFFF_FF80));
        rows.push_back(typed_row(OP_DECODE, 32'h0, 32'h7F, 16'd1, 1, 32'h7F, 32'h7F));
        // empty field: zero size, nothing moves, no sign
        rows.push_back(cfg_row(CFG_FIELD_MASK, 32'h0));
        rows.push_back(typed_row(OP_ENCODE, 32'hFFFF_FFFF, 32'h89AB_CDEF, 16'd0,
                                 1, 32'h89AB_CDEF, 0));
        rows.push_back(typed_row(OP_DECODE, 32'h0, 32'hFFFF_FFFF, 16'd0,
                                 1, 32'hFFFF_FFFF, 0));
        // full mask at the top offset: offset plus size must not wrap
        rows.push_back(cfg_row(CFG_FIELD_MASK, 32'hFFFF_FFFF));
        rows.push_back(cfg_row(CFG_FIELD_OFFSET, 32'd65535));
        rows.push_back(typed_row(OP_DECODE, 32'h0, 32'h8000_0000, 16'hFFFF,
                                 0, 32'h8000_0000, 0));
        rows.push_back(typed_row(OP_ENCODE, 32'h1, 32'h0, 16'hFFFF, 0, 32'h0, 0));
        rows.push_back(cfg_row(CFG_FIELD_OFFSET, 32'd65531));
        rows.push_back(word_row(OP_DECODE, 32'h0, 32'h8000_0000, 16'hFFFF));
        rows.push_back(word_row(OP_ENCODE, 32'h1234_5678, 32'hFFFF_FFFF, 16'hFFFF));
        rows.push_back(typed_row(OP_DECODE, 32'h0, 32'h1, 16'hFFFE, 0, 32'h1, 0));
        // scattered two-bit field spanning all four bytes
        rows.push_back(cfg_row(CFG_FIELD_MASK, 32'h8000_0001));
        rows.push_back(cfg_row(CFG_FIELD_OFFSET, 32'd0));
        rows.push_back(word_row(OP_ENCODE, 32'd3, 32'h7FFF_FFFE, 16'd4));
        rows.push_back(word_row(OP_DECODE, 32'h0, 32'h8000_0000, 16'd4));
        rows.push_back(typed_row(OP_ENCODE, 32'd3, 32'h0, 16'd3, 0, 32'h0, 0));
        rows.push_back(cfg_row(CFG_FIELD_MASK, 32'h00F0_F000));
        rows.push_back(cfg_row(CFG_SIGN_EXTEND, 32'd0));
        rows.push_back(word_row(OP_DECODE, 32'h0, 32'hA5C3_E7FF, 16'd3));
        rows.push_back(word_row(OP_ENCODE, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 16'd3));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_stalls = 1'b1;

        foreach (rows[i]) begin
            r = rows[i];
            if (r.is_cfg) begin
                wait_idle();
                write_reg(r.idx, r.data);
            end else begin
                send_word(r.w);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin pm = 32'hFFFF_FFFF; po = 16'd0; end
                1: begin pm = 32'h1;         po = 16'hFFFF; end
                2: begin pm = 32'h8000_0000; po = 16'd65531; end
                default: begin pm = pick_mask(); po = pick_offset(); end
            endcase
            wait_idle();
            write_reg(CFG_FIELD_MASK, pm);
            write_reg(CFG_FIELD_OFFSET, {16'h0, po});
            write_reg(CFG_SIGN_EXTEND, (ph == 2) ? 32'd1 : 32'($urandom_range(0, 1)));
            rx_stalls = (ph % 4) != 3;
            tx_gaps   = (ph % 5) != 4;
            need = int'(po) + field_size(pm);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // lengths cluster around the bounds threshold
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(0, 65535);
                    1: len = 0;
                    2: len = 65535;
                    default: len = need + $urandom_range(0, 4) - 2;
                endcase
                if (len < 0) len = 0;
                if (len > 65535) len = 65535;
                r = word_row($urandom_range(0, 1) ? OP_DECODE : OP_ENCODE,
                             $urandom, $urandom, 16'(len));
                send_word(r.w);
                if ($urandom_range(0, 149) == 0) begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_mismatch++;
        end
        if (n_mismatch == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> masked_bitfield_codec.f
design/mbc_pkg.sv
design/masked_bitfield_codec.sv
test/masked_bitfield_codec_test.sv
